FILE: rtl/hlbc_pkg.sv
package hlbc_pkg;

  localparam int DefNumBuffers = 32;
  localparam int DefNumBuckets = 13;
  localparam logic [7:0] RefMax = 8'd255;

  typedef enum logic [1:0] {
    MODE_GET     = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_PIN     = 2'd2,
    MODE_UNPIN   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_COUNT   = 2'd2
  } status_t;

endpackage

FILE: rtl/hlbc_mod.sv
// Bucket index from a block number: fold the bytes by their weights modulo the bucket count,
// then take the remainder of the small sum by a reciprocal multiply, each step registered.
module hlbc_mod import hlbc_pkg::*; #(
  parameter int NUM_BUCKETS = DefNumBuckets,
  parameter int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  output logic          done,
  output logic [BW-1:0] remainder
);

  // Weight of byte k: 2^(8k) modulo the bucket count
  function automatic int byte_weight(input int k);
    int w;
    w = 1 % NUM_BUCKETS;
    for (int i = 0; i < k; i++) w = (w * 256) % NUM_BUCKETS;
    return w;
  endfunction

  localparam int RecipShift = 23;
  localparam int Recip = ((1 << RecipShift) + NUM_BUCKETS - 1) / NUM_BUCKETS;
  localparam logic [15:0] Wt0 = 16'(byte_weight(0));
  localparam logic [15:0] Wt1 = 16'(byte_weight(1));
  localparam logic [15:0] Wt2 = 16'(byte_weight(2));
  localparam logic [15:0] Wt3 = 16'(byte_weight(3));
  localparam logic [23:0] RecipW = 24'(Recip);
  localparam logic [15:0] Modulus = 16'(NUM_BUCKETS);

  logic [15:0]   fold_r, fold_nxt;
  logic [39:0]   prod_r;
  logic [15:0]   quot;
  logic [15:0]   diff;
  logic [BW-1:0] rem_r;
  logic          v1_r, v2_r, done_r;

  // Fold the bytes; the weighted sum keeps the remainder and fits in 16 bits
  assign fold_nxt = 16'(dividend[7:0]) * Wt0 + 16'(dividend[15:8]) * Wt1 +
                    16'(dividend[23:16]) * Wt2 + 16'(dividend[31:24]) * Wt3;

  // Quotient of the folded sum, exact below 2^16, then the remainder
  assign quot = prod_r[RecipShift +: 16];
  assign diff = fold_r - quot * Modulus;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
    if (start) fold_r <= fold_nxt;
    if (v1_r) prod_r <= 40'(fold_r) * 40'(RecipW);
    if (v2_r) rem_r <= diff[BW-1:0];
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/hashed_lru_buffer_cache_tags.sv
// Sequence: a get takes its home bucket from a registered remainder, then sweeps the buffer
//   memory, one entry a cycle: a hit search that ends at a hit, then on a miss a search of
//   the home bucket and, if that finds no free buffer, a steal search and a rank renumbering
//   sweep; release, pin and unpin update the handle's entry, and a release that reorders the
//   bucket ranks adds a renumbering sweep. Throughput: one transaction at a time; the next
//   one is taken the cycle after the result leaves. Reset: synchronous, active low; a sweep
//   then writes the initial bucket and rank of every buffer before the first transaction.
module hashed_lru_buffer_cache_tags import hlbc_pkg::*; #(
  parameter int NUM_BUFFERS = DefNumBuffers,
  parameter int NUM_BUCKETS = DefNumBuckets
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_device_id,
  input  logic [31:0] in_block_number,
  input  logic [4:0]  in_buffer_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_buffer_index,
  output logic        out_needs_fill,
  output logic [1:0]  out_status,
  output logic [7:0]  out_references
);

  localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CW = $clog2(NUM_BUFFERS + 1);
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int BCW = $clog2(NUM_BUCKETS + 1);

  typedef struct packed {
    logic [15:0]   dev;
    logic [31:0]   blk;
    logic          present;
    logic          cvalid;
    logic [7:0]    refs;
    logic [BW-1:0] bucket;
    logic [IW-1:0] rank;
  } entry_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MOD, S_HIT, S_HOME, S_STEAL, S_FIX, S_HREAD, S_HDONE,
    S_WRITE, S_PLACE, S_OUT
  } state_t;

  // Buffer table, one read port and one write port
  entry_t mem [NUM_BUFFERS];
  entry_t rd_q;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  state_t state_r;
  logic [CW-1:0]  scan_r;      // address issued last cycle (data in rd_q now)
  logic           rdv_r;       // rd_q holds a sweep entry
  logic [1:0]     mode_r;
  logic [15:0]    dev_r;
  logic [31:0]    blk_r;
  logic [4:0]     hnd_r;
  logic [BW-1:0]  home_r;
  logic           found_r;
  logic [IW-1:0]  vic_r;
  entry_t         vic_e_r;
  logic [BW-1:0]  old_b_r;
  logic [IW-1:0]  old_rank_r;
  logic [BW-1:0]  new_b_r;
  logic [CW-1:0]  new_cnt_r;
  logic           move_r;
  logic [4:0]     o_idx_r;
  logic           o_fill_r;
  logic [1:0]     o_st_r;
  logic [7:0]     o_refs_r;
  logic           out_valid_r;
  // bucket of the best free candidate during the steal sweep
  logic [BCW-1:0] best_b_r;
  // initial bucket and rank of the entry being written after reset
  logic [BW-1:0]  init_b_r;
  logic [IW-1:0]  init_rank_r;

  logic mod_start, mod_done;
  logic [BW-1:0] mod_rem;

  hlbc_mod #(.NUM_BUCKETS(NUM_BUCKETS), .BW(BW)) u_mod (
    .clk, .rst_n, .start(mod_start), .dividend(in_block_number),
    .done(mod_done), .remainder(mod_rem)
  );

  logic accept;
  assign in_stall  = !(state_r == S_IDLE && !out_valid_r && !wr_en);
  assign accept    = in_valid && !in_stall;
  assign mod_start = accept && mode_t'(in_mode) == MODE_GET;

  logic last;
  assign last = (scan_r == CW'(NUM_BUFFERS - 1));

  // Read address: next sweep entry, the handle when idle, or entry zero before a sweep
  always_comb begin
    rd_addr = scan_r[IW-1:0] + IW'(1);
    if (state_r == S_IDLE) rd_addr = in_buffer_handle[IW-1:0];
    else if (state_r == S_MOD || state_r == S_FIX || state_r == S_HDONE ||
             (state_r == S_WRITE && !rdv_r)) rd_addr = '0;
  end

  entry_t rd_fix;
  always_comb begin
    rd_fix = rd_q;
    // sweep to renumber ranks for a move
    if (rd_q.bucket == old_b_r && rd_q.rank > old_rank_r) rd_fix.rank = rd_q.rank - IW'(1);
  end

  logic cand;
  assign cand = rd_q.refs == 8'd0;

  // Sequencer: one clocked block holds state and registered outputs
  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (!rst_n) begin
      state_r     <= S_INIT;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
      init_b_r    <= '0;
      init_rank_r <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_INIT: begin
          wr_en   <= 1'b1;
          wr_addr <= scan_r[IW-1:0];
          wr_data <= '{dev: '0, blk: '0, present: 1'b0, cvalid: 1'b0, refs: '0,
                       bucket: init_b_r, rank: init_rank_r};
          if (init_b_r == BW'(NUM_BUCKETS - 1)) begin
            init_b_r    <= '0;
            init_rank_r <= init_rank_r + IW'(1);
          end else begin
            init_b_r <= init_b_r + BW'(1);
          end
          scan_r  <= scan_r + CW'(1);
          if (last) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            mode_r  <= in_mode;
            dev_r   <= in_device_id;
            blk_r   <= in_block_number;
            hnd_r   <= in_buffer_handle;
            found_r <= 1'b0;
            move_r  <= 1'b0;
            o_fill_r <= 1'b0;
            if (mode_t'(in_mode) == MODE_GET) state_r <= S_MOD;
            else state_r <= S_HREAD;
          end
        end
        S_MOD: begin
          scan_r <= '0;
          if (mod_done) begin
            home_r  <= mod_rem;
            state_r <= S_HIT;
          end
        end
        // Hit search in the home bucket
        S_HIT: begin
          scan_r <= scan_r + CW'(1);
          if (rd_q.bucket == home_r && rd_q.present && rd_q.dev == dev_r &&
              rd_q.blk == blk_r) begin
            vic_r <= scan_r[IW-1:0];
            vic_e_r <= rd_q;
            o_idx_r <= 5'(scan_r);
            if (rd_q.refs >= RefMax) begin
              o_st_r <= ST_COUNT;
              o_refs_r <= rd_q.refs;
              state_r <= S_OUT;
            end else begin
              o_st_r <= ST_OK;
              o_refs_r <= rd_q.refs + 8'd1;
              o_fill_r <= !rd_q.cvalid;
              wr_en <= 1'b1;
              wr_addr <= scan_r[IW-1:0];
              wr_data <= rd_q;
              wr_data.refs <= rd_q.refs + 8'd1;
              wr_data.cvalid <= 1'b1;
              state_r <= S_OUT;
            end
          end else if (last) begin
            scan_r <= '0;
            state_r <= S_FIX;
            best_b_r <= BCW'(home_r);
          end
        end
        S_FIX: begin
          scan_r <= '0;
          state_r <= (best_b_r == BCW'(home_r) && !found_r) ? S_HOME : S_STEAL;
          best_b_r <= BCW'(NUM_BUCKETS);
        end
        // Oldest free in home bucket
        S_HOME: begin
          scan_r <= scan_r + CW'(1);
          if (rd_q.bucket == home_r && cand &&
              (!found_r || rd_q.rank < vic_e_r.rank)) begin
            found_r <= 1'b1;
            vic_r <= scan_r[IW-1:0];
            vic_e_r <= rd_q;
          end
          if (last) begin
            scan_r <= '0;
            state_r <= S_HDONE;
          end
        end
        S_HDONE: begin
          scan_r <= '0;
          if (found_r) state_r <= S_WRITE;
          else state_r <= S_STEAL;
        end
        // Oldest free in lowest bucket that has one
        S_STEAL: begin
          scan_r <= scan_r + CW'(1);
          if (cand && (!found_r || BCW'(rd_q.bucket) < best_b_r ||
              (BCW'(rd_q.bucket) == best_b_r && rd_q.rank < vic_e_r.rank))) begin
            found_r <= 1'b1;
            best_b_r <= BCW'(rd_q.bucket);
            vic_r <= scan_r[IW-1:0];
            vic_e_r <= rd_q;
          end
          if (last) begin
            scan_r <= '0;
            if (!found_r && !(cand)) begin
              o_idx_r <= '0; o_st_r <= ST_NO_FREE; o_refs_r <= '0;
              state_r <= S_OUT;
            end else begin
              move_r <= 1'b1;
              state_r <= S_WRITE;
            end
          end
        end
        // Handle operations: read the entry
        S_HREAD: begin
          o_idx_r <= hnd_r;
          o_st_r <= ST_OK;
          state_r <= S_OUT;
          if (32'(hnd_r) >= 32'(NUM_BUFFERS)) begin
            o_st_r <= ST_COUNT; o_refs_r <= '0;
          end else if (mode_t'(mode_r) == MODE_PIN) begin
            if (rd_q.refs >= RefMax) begin
              o_st_r <= ST_COUNT; o_refs_r <= rd_q.refs;
            end else begin
              o_refs_r <= rd_q.refs + 8'd1;
              wr_en <= 1'b1; wr_addr <= hnd_r[IW-1:0];
              wr_data <= rd_q; wr_data.refs <= rd_q.refs + 8'd1;
            end
          end else if (rd_q.refs == 8'd0) begin
            o_st_r <= ST_COUNT; o_refs_r <= '0;
          end else begin
            o_refs_r <= rd_q.refs - 8'd1;
            vic_r <= hnd_r[IW-1:0];
            vic_e_r <= rd_q;
            vic_e_r.refs <= rd_q.refs - 8'd1;
            if (mode_t'(mode_r) == MODE_RELEASE && rd_q.refs == 8'd1) begin
              move_r <= 1'b1;
              new_b_r <= rd_q.bucket;
              old_b_r <= rd_q.bucket;
              old_rank_r <= rd_q.rank;
              new_cnt_r <= '0;
              scan_r <= '0;
              rdv_r <= 1'b0;
              state_r <= S_WRITE;
            end else begin
              wr_en <= 1'b1; wr_addr <= hnd_r[IW-1:0];
              wr_data <= rd_q; wr_data.refs <= rd_q.refs - 8'd1;
            end
          end
        end
        // Rank renumbering sweep (for a move), then write the chosen entry
        S_WRITE: begin
          if (!move_r) begin
            wr_en <= 1'b1; wr_addr <= vic_r;
            wr_data <= '{dev: dev_r, blk: blk_r, present: 1'b1, cvalid: 1'b1,
                         refs: 8'd1, bucket: vic_e_r.bucket, rank: vic_e_r.rank};
            o_idx_r <= 5'(vic_r); o_fill_r <= 1'b1; o_st_r <= ST_OK; o_refs_r <= 8'd1;
            state_r <= S_OUT;
          end else if (!rdv_r) begin
            if (mode_t'(mode_r) == MODE_GET) begin
              old_b_r <= vic_e_r.bucket; old_rank_r <= vic_e_r.rank;
              new_b_r <= home_r; new_cnt_r <= '0;
            end
            rdv_r <= 1'b1;
            scan_r <= '0;
          end else begin
            scan_r <= scan_r + CW'(1);
            if (scan_r[IW-1:0] != vic_r) begin
              if (rd_q.bucket == new_b_r) new_cnt_r <= new_cnt_r + CW'(1);
              wr_en <= 1'b1; wr_addr <= scan_r[IW-1:0]; wr_data <= rd_fix;
            end
            if (last) begin
              rdv_r <= 1'b0;
              move_r <= 1'b0;
              state_r <= S_PLACE;
            end
          end
        end
        // Place the moved entry at the head of its new bucket
        S_PLACE: begin
          wr_en <= 1'b1; wr_addr <= vic_r;
          state_r <= S_OUT;
          if (mode_t'(mode_r) == MODE_GET) begin
            wr_data <= '{dev: dev_r, blk: blk_r, present: 1'b1, cvalid: 1'b1,
                         refs: 8'd1, bucket: new_b_r, rank: IW'(new_cnt_r)};
            o_idx_r <= 5'(vic_r); o_fill_r <= 1'b1; o_st_r <= ST_OK;
            o_refs_r <= 8'd1;
          end else begin
            wr_data <= vic_e_r;
            wr_data.rank <= IW'(new_cnt_r);
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_buffer_index = o_idx_r;
  assign out_needs_fill   = o_fill_r;
  assign out_status       = o_st_r;
  assign out_references   = o_refs_r;

endmodule

FILE: rtl/hlbc_checker.sv
module hlbc_checker import hlbc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_needs_fill,
  input logic [1:0] out_status,
  input logic [4:0] out_buffer_index
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_buffer_index))
    else $error("result changed under stall");

  // Fill only on success
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_needs_fill |-> out_status == ST_OK)
    else $error("fill flagged with error");

  // Status code in range
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status");

  // No new transaction while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken with result pending");

endmodule

bind hashed_lru_buffer_cache_tags hlbc_checker u_chk (.*);

FILE: sim/hashed_lru_buffer_cache_tags_checker.sv
module hashed_lru_buffer_cache_tags_checker import hlbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_device_id,
  input  logic [31:0] in_block_number,
  input  logic [4:0]  in_buffer_handle,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [4:0]  out_buffer_index,
  input  logic        out_needs_fill,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_references,
  output int          mismatches,
  output int          pending,
  output int          gets_done,
  output int          hits_seen,
  output int          steals_seen,
  output int          no_free_seen,
  output int          count_errs_seen
);

  localparam int NB = DefNumBuffers;
  localparam int NK = DefNumBuckets;

  typedef struct packed {
    logic [4:0] index;
    logic       fill;
    status_t    status;
    logic [7:0] refs;
  } cache_result_t;

  logic [15:0] tag_dev [NB];
  logic [31:0] tag_blk [NB];
  logic        tag_held [NB];
  logic        filled [NB];
  logic [7:0]  refcnt [NB];
  int          bucket_of [NB];
  int          rank_of [NB];

  cache_result_t expected_results[$];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Move a buffer to the most recent slot of a bucket, closing the gap it leaves.
  function automatic void promote(input int i, input int b);
    int cnt;
    cnt = 0;
    for (int j = 0; j < NB; j++)
      if (j != i && bucket_of[j] == bucket_of[i] && rank_of[j] > rank_of[i]) rank_of[j]--;
    for (int j = 0; j < NB; j++)
      if (j != i && bucket_of[j] == b) cnt++;
    bucket_of[i] = b;
    rank_of[i] = cnt;
  endfunction

  function automatic int least_recent_idle(input int b);
    int best;
    best = NB;
    for (int j = 0; j < NB; j++)
      if (bucket_of[j] == b && refcnt[j] == 0 &&
          (best == NB || rank_of[j] < rank_of[best])) best = j;
    return best;
  endfunction

  // Compute the result of one transaction and update the shadow tags.
  function automatic cache_result_t predict_lookup(input mode_t md, input logic [15:0] dev,
                                                   input logic [31:0] blk,
                                                   input logic [4:0] h);
    cache_result_t r;
    int home, hit, v;
    r = '{index: '0, fill: 1'b0, status: ST_OK, refs: '0};
    if (md == MODE_GET) begin
      gets_done++;
      home = blk % NK;
      hit = NB;
      for (int j = 0; j < NB; j++)
        if (hit == NB && bucket_of[j] == home && tag_held[j] &&
            tag_dev[j] == dev && tag_blk[j] == blk) hit = j;
      if (hit < NB) begin
        hits_seen++;
        r.index = hit[4:0];
        if (refcnt[hit] >= RefMax) begin
          r.status = ST_COUNT;
          count_errs_seen++;
        end else begin
          refcnt[hit]++;
          r.fill = !filled[hit];
          filled[hit] = 1'b1;
        end
        r.refs = refcnt[hit];
      end else begin
        v = least_recent_idle(home);
        if (v == NB) begin
          for (int b = 0; b < NK && v == NB; b++) v = least_recent_idle(b);
          if (v < NB) begin
            promote(v, home);
            steals_seen++;
          end
        end
        if (v == NB) begin
          r.status = ST_NO_FREE;
          no_free_seen++;
        end else begin
          tag_dev[v] = dev;
          tag_blk[v] = blk;
          tag_held[v] = 1'b1;
          refcnt[v] = 8'd1;
          filled[v] = 1'b1;
          r.fill = 1'b1;
          r.index = v[4:0];
          r.refs = 8'd1;
        end
      end
    end else begin
      r.index = h;
      if (h >= NB) begin
        r.status = ST_COUNT;
      end else if (md == MODE_PIN) begin
        if (refcnt[h] >= RefMax) r.status = ST_COUNT;
        else refcnt[h]++;
        r.refs = refcnt[h];
      end else begin
        if (refcnt[h] == 0) begin
          r.status = ST_COUNT;
        end else begin
          refcnt[h]--;
          if (md == MODE_RELEASE && refcnt[h] == 0) promote(h, bucket_of[h]);
        end
        r.refs = refcnt[h];
      end
      if (r.status == ST_COUNT) count_errs_seen++;
    end
    return r;
  endfunction

  // Predict on each accepted request, compare each accepted result.
  always @(posedge clk) begin
    cache_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        tag_held[i] = 1'b0;
        filled[i] = 1'b0;
        refcnt[i] = '0;
        bucket_of[i] = i % NK;
        rank_of[i] = i / NK;
      end
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result transaction at %0t", $realtime);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_buffer_index !== want.index) report("buffer_index", out_buffer_index, want.index);
          if (out_needs_fill !== want.fill) report("needs_fill", out_needs_fill, want.fill);
          if (out_status !== want.status) report("status", out_status, want.status);
          if (out_references !== want.refs) report("references", out_references, want.refs);
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_lookup(mode_t'(in_mode), in_device_id,
                                                  in_block_number, in_buffer_handle));
    end
    pending = expected_results.size();
  end

  initial begin
    mismatches = 0;
    pending = 0;
    gets_done = 0;
    hits_seen = 0;
    steals_seen = 0;
    no_free_seen = 0;
    count_errs_seen = 0;
  end

endmodule

FILE: sim/hashed_lru_buffer_cache_tags_test.sv
module hashed_lru_buffer_cache_tags_test;
  import hlbc_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [15:0] in_device_id;
  logic [31:0] in_block_number;
  logic [4:0]  in_buffer_handle;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_buffer_index;
  logic        out_needs_fill;
  logic [1:0]  out_status;
  logic [7:0]  out_references;

  int mismatches, pending, gets_done, hits_seen, steals_seen, no_free_seen, count_errs_seen;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  int idle_cycles;
  logic [4:0] handles_held[$];

  hashed_lru_buffer_cache_tags dut (.*);

  hashed_lru_buffer_cache_tags_checker checker_i (.*);

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Drive the receiver's stall: random, or held off for a long stretch.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("FAIL");
      $finish;
    end
  end

  // Offer one request, with random leading gaps, and hold it until accepted.
  task automatic send_request(input mode_t md, input logic [15:0] dev,
                              input logic [31:0] blk, input logic [4:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= md;
    in_device_id <= dev;
    in_block_number <= blk;
    in_buffer_handle <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic get_block(input logic [15:0] dev, input logic [31:0] blk);
    send_request(MODE_GET, dev, blk, 5'($urandom));
  endtask

  task automatic act_on(input mode_t md, input logic [4:0] h);
    send_request(md, 16'($urandom), $urandom, h);
  endtask

  // Mostly sensible traffic over a small working set, plus noise.
  task automatic random_traffic(input int n);
    int pick;
    int k;
    logic [4:0] h;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        get_block(16'($urandom_range(3)), 32'($urandom_range(60)));
      end else if (pick < 45) begin
        get_block(16'($urandom), $urandom);
      end else if (pick < 75 && handles_held.size() > 0) begin
        k = $urandom_range(handles_held.size() - 1);
        h = handles_held[k];
        handles_held.delete(k);
        act_on(($urandom_range(3) == 0) ? MODE_UNPIN : MODE_RELEASE, h);
      end else if (pick < 85) begin
        h = 5'($urandom);
        handles_held.push_back(h);
        act_on(MODE_PIN, h);
      end else begin
        act_on(mode_t'($urandom_range(1, 3)), 5'($urandom));
      end
      if (handles_held.size() > 40) handles_held.delete(0);
    end
  endtask

  // Drop valid after the last accepted request and wait for all results.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_GET;
    in_device_id = '0;
    in_block_number = '0;
    in_buffer_handle = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every mode, count errors, stealing, exhaustion.
    get_block(16'hFFFF, 32'hFFFF_FFFF);
    get_block(16'hFFFF, 32'hFFFF_FFFF);
    get_block(16'h0000, 32'h0000_0000);
    act_on(MODE_RELEASE, 5'd0);
    act_on(MODE_RELEASE, 5'd0);
    act_on(MODE_UNPIN, 5'd31);
    act_on(MODE_PIN, 5'd31);
    act_on(MODE_UNPIN, 5'd31);
    act_on(MODE_PIN, 5'd1);
    act_on(MODE_RELEASE, 5'd1);
    for (int i = 0; i < 6; i++) get_block(16'h5A5A, 32'd13 * i + 32'd7);
    for (int i = 0; i < 255; i++) act_on(MODE_PIN, 5'd20);
    act_on(MODE_PIN, 5'd20);
    for (int i = 0; i < 34; i++) get_block(16'h00A5, 32'h8000_0000 + 32'(i));
    for (int i = 0; i < 32; i++) act_on(MODE_RELEASE, 5'(i));
    for (int i = 0; i < 32; i++) act_on(MODE_UNPIN, 5'(i));
    drain();

    // Random phases with differing idle and stall rates.
    send_idle_pct = 0;  recv_stall_pct = 0;  random_traffic(70);
    send_idle_pct = 46; recv_stall_pct = 0;  random_traffic(70);
    send_idle_pct = 0;  recv_stall_pct = 46; random_traffic(70);
    send_idle_pct = 29; recv_stall_pct = 29; random_traffic(70);

    // Hold off the receiver for a long stretch while requests keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    random_traffic(100);
    drain();

    $display("ran %0d gets: %0d hits, %0d steals, %0d no-free, %0d count errors",
             gets_done, hits_seen, steals_seen, no_free_seen, count_errs_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
